@@ rtl/philox_pkg.sv @@
`default_nettype none

package philox_pkg;

  localparam logic [31:0] MUL_B   = 32'hCD9E8D57;
  localparam logic [31:0] MUL_D   = 32'hD2511F53;
  localparam logic [31:0] BUMP_K0 = 32'hBB67AE85;
  localparam logic [31:0] BUMP_K1 = 32'h9E3779B9;

  localparam int KEEP_BITS = 24;
  localparam int LEAD_W    = $clog2(KEEP_BITS);
  localparam logic [7:0] EXP_BASE = 8'(127 - KEEP_BITS);

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } philox_state_t;

  typedef logic [1:0] reg_index_t;

  localparam reg_index_t REG_SEED  = 2'd0;
  localparam reg_index_t REG_FLOAT = 2'd1;

  function automatic logic [LEAD_W-1:0] lead_pos(input logic [KEEP_BITS-1:0] v);
    logic [LEAD_W-1:0] p;
    p = '0;
    for (int i = 0; i < KEEP_BITS; i++) begin
      if (v[i]) begin
        p = LEAD_W'(i);
      end
    end
    return p;
  endfunction

  function automatic logic [31:0] unit_float(input logic [KEEP_BITS-1:0] v,
                                             input logic [LEAD_W-1:0] p);
    logic [KEEP_BITS-1:0] norm;
    logic [7:0]           expo;
    logic [LEAD_W-1:0]    sh;
    sh   = LEAD_W'(KEEP_BITS - 1) - p;
    norm = v << sh;
    expo = EXP_BASE + 8'(p);
    if (v == '0) begin
      return 32'h0000_0000;
    end
    return {1'b0, expo, norm[22:0]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/philox_round.sv @@
`default_nettype none

module philox_round (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  input  philox_pkg::philox_state_t  in_state,
  input  wire  [31:0]                k0,
  input  wire  [31:0]                k1,
  output logic                       out_valid,
  output philox_pkg::philox_state_t  out_state
);
  import philox_pkg::*;

  logic [63:0]   prod_b;
  logic [63:0]   prod_d;
  philox_state_t state_next;

  assign prod_b = {32'b0, in_state.b} * {32'b0, MUL_B};
  assign prod_d = {32'b0, in_state.d} * {32'b0, MUL_D};

  always_comb begin
    state_next.a = prod_b[31:0];
    state_next.b = prod_d[63:32] ^ k1 ^ in_state.c;
    state_next.c = prod_d[31:0];
    state_next.d = prod_b[63:32] ^ k0 ^ in_state.a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_state <= state_next;
  end

endmodule

`default_nettype wire

@@ rtl/philox_float.sv @@
`default_nettype none

module philox_float (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  input  philox_pkg::philox_state_t  in_state,
  input  wire                        float_mode,
  output logic                       out_valid,
  output philox_pkg::philox_state_t  out_state
);
  import philox_pkg::*;

  logic              valid1;
  logic              mode1;
  philox_state_t     state1;
  logic [LEAD_W-1:0] lead1 [4];
  logic [LEAD_W-1:0] lead_next [4];
  philox_state_t     state_next;

  always_comb begin
    lead_next[0] = lead_pos(in_state.a[31 -: KEEP_BITS]);
    lead_next[1] = lead_pos(in_state.b[31 -: KEEP_BITS]);
    lead_next[2] = lead_pos(in_state.c[31 -: KEEP_BITS]);
    lead_next[3] = lead_pos(in_state.d[31 -: KEEP_BITS]);
  end

  always_comb begin
    if (mode1) begin
      state_next.a = unit_float(state1.a[31 -: KEEP_BITS], lead1[0]);
      state_next.b = unit_float(state1.b[31 -: KEEP_BITS], lead1[1]);
      state_next.c = unit_float(state1.c[31 -: KEEP_BITS], lead1[2]);
      state_next.d = unit_float(state1.d[31 -: KEEP_BITS], lead1[3]);
    end else begin
      state_next = state1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid1    <= in_valid;
      out_valid <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    state1    <= in_state;
    mode1     <= float_mode;
    lead1     <= lead_next;
    out_state <= state_next;
  end

endmodule

`default_nettype wire

@@ rtl/philox_counter_rng.sv @@
// Channel   Ports                        Handshake
// ------    ---------------------------  ------------------------------------
// request   start, busy, counter         taken when start is high, busy low
// result    done, word0..word3           done marks a one-cycle result
// config    wr_en, wr_index, wr_data     written when wr_en is high
//
// One request can be taken every cycle while busy is low; each round is one
// pipeline stage with two 32x32 multipliers; float conversion is two stages.
// Reset clears all valid bits and the seed and float registers; busy is high
// during reset and in the first cycle after it. The receiver cannot stall
// the results.
`default_nettype none

module philox_counter_rng #(
  parameter int ROUNDS = 10
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire  [63:0]                 counter,
  output logic                        done,
  output logic [31:0]                 word0,
  output logic [31:0]                 word1,
  output logic [31:0]                 word2,
  output logic [31:0]                 word3,
  input  wire                         wr_en,
  input  philox_pkg::reg_index_t      wr_index,
  input  wire  [63:0]                 wr_data
);
  import philox_pkg::*;

  localparam int LATENCY = ROUNDS + 2;

  logic [63:0]   seed;
  logic          float_output;
  logic          stage_valid [ROUNDS+1];
  philox_state_t stage_state [ROUNDS+1];
  philox_state_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed         <= '0;
      float_output <= 1'b0;
      busy         <= 1'b1;
    end else begin
      busy <= 1'b0;
      if (wr_en) begin
        unique case (wr_index)
          REG_SEED:  seed         <= wr_data;
          REG_FLOAT: float_output <= wr_data[0];
          default:   ;
        endcase
      end
    end
  end

  assign stage_valid[0]   = start && !busy;
  assign stage_state[0].a = 32'b0;
  assign stage_state[0].b = 32'b0;
  assign stage_state[0].c = counter[63:32];
  assign stage_state[0].d = counter[31:0];

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam logic [31:0] K0_OFF = 32'(r) * BUMP_K0;
    localparam logic [31:0] K1_OFF = 32'(r) * BUMP_K1;

    logic [31:0] k0;
    logic [31:0] k1;

    assign k0 = seed[31:0] + K0_OFF;
    assign k1 = seed[63:32] + K1_OFF;

    philox_round u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[r]),
      .in_state  (stage_state[r]),
      .k0        (k0),
      .k1        (k1),
      .out_valid (stage_valid[r+1]),
      .out_state (stage_state[r+1])
    );
  end

  philox_float u_float (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (stage_valid[ROUNDS]),
    .in_state   (stage_state[ROUNDS]),
    .float_mode (float_output),
    .out_valid  (done),
    .out_state  (result)
  );

  assign word0 = result.a;
  assign word1 = result.b;
  assign word2 = result.c;
  assign word3 = result.d;

  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  a_float_below_one: assert property (@(posedge clk) disable iff (rst)
    (done && float_output) |-> (!word0[30] && !word1[30] && !word2[30] && !word3[30]))
    else $error("float result not below one");

  a_float_no_denormal: assert property (@(posedge clk) disable iff (rst)
    (done && float_output && word1[30:23] == 8'd0) |-> (word1 == 32'b0))
    else $error("float result is denormal");

endmodule

`default_nettype wire
